// ===== hw/rtl/cdate_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdate_pkg
// Shared types, constants and arithmetic helpers for the calendar date counter.
// ----------------------------------------------------------------------------
package cdate_pkg;

    localparam int unsigned DEF_LAST_YEAR = 9999;

    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YEAR_W  = 14;

    typedef enum logic [1:0] {
        FUNC_LOAD = 2'd0,
        FUNC_NEXT = 2'd1,
        FUNC_PREV = 2'd2
    } t_func;

    // Stored date plus flags kept alongside it for the next update.
    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic               known;
        logic               leap;
        logic               ok;
    } t_date_state;

    // Floor of y / 100 for y below 25600, by reciprocal multiply.
    function automatic logic [7:0] div100(input logic [14:0] y);
        logic [27:0] p;
        p = 28'(y) * 28'd5243;
        return p[26:19];
    endfunction

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [7:0]  q;
        logic [14:0] r;
        q = div100({1'b0, y});
        r = {1'b0, y} - 15'(q) * 15'd100;
        return (y[1:0] == 2'd0) && ((r != 15'd0) || (q[1:0] == 2'd0));
    endfunction

    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
        logic [DAY_W-1:0] d;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
            4'd2:                                       d = leap ? 5'd29 : 5'd28;
            default:                                    d = 5'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== hw/rtl/cdate_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdate_step
// Next-date logic: load, advance one day or step back one day.
// ----------------------------------------------------------------------------
module cdate_step #(
    parameter int unsigned LAST_YEAR = cdate_pkg::DEF_LAST_YEAR
) (
    input  cdate_pkg::t_date_state              i_state,
    input  logic [1:0]                          i_func,
    input  logic [cdate_pkg::DAY_W-1:0]         i_load_day,
    input  logic [cdate_pkg::MONTH_W-1:0]       i_load_month,
    input  logic [cdate_pkg::YEAR_W-1:0]        i_load_year,
    output cdate_pkg::t_date_state              o_state
);
    import cdate_pkg::*;

    localparam logic [YEAR_W-1:0] LastYr = YEAR_W'(LAST_YEAR);

    logic [YEAR_W-1:0]  year_p1;
    logic [YEAR_W-1:0]  year_m1;
    logic               leap_p1;
    logic               leap_m1;
    logic               leap_ld;
    logic [DAY_W-1:0]   dim_cur;
    logic [DAY_W-1:0]   dim_prev;
    logic [MONTH_W-1:0] ld_month;
    logic               ld_month_ok;
    logic               ld_year_ok;
    logic               ld_leap;

    assign year_p1     = i_state.year + YEAR_W'(1);
    assign year_m1     = i_state.year - YEAR_W'(1);
    assign leap_p1     = is_leap(year_p1);
    assign leap_m1     = is_leap(year_m1);
    assign leap_ld     = is_leap(i_load_year);
    assign dim_cur     = days_in(i_state.month, i_state.leap);
    assign dim_prev    = days_in(i_state.month - MONTH_W'(1), i_state.leap);

    assign ld_month_ok = (i_load_month >= 4'd1) && (i_load_month <= 4'd12);
    assign ld_month    = ld_month_ok ? i_load_month : '0;
    assign ld_year_ok  = (i_load_year <= LastYr);
    assign ld_leap     = ld_year_ok ? leap_ld : 1'b1;

    always_comb begin
        o_state = i_state;
        unique case (t_func'(i_func))
            FUNC_LOAD: begin
                o_state.day   = i_load_day;
                o_state.month = ld_month;
                o_state.year  = ld_year_ok ? i_load_year : '0;
                o_state.known = ld_year_ok;
                o_state.leap  = ld_leap;
                o_state.ok    = ld_year_ok && ld_month_ok && (i_load_day != '0) &&
                                (i_load_day <= days_in(ld_month, ld_leap));
            end
            FUNC_NEXT: begin
                if (i_state.ok) begin
                    if (i_state.day == dim_cur) begin
                        if (i_state.month == 4'd12) begin
                            if (i_state.year < LastYr) begin
                                o_state.day   = 5'd1;
                                o_state.month = 4'd1;
                                o_state.year  = year_p1;
                                o_state.leap  = leap_p1;
                            end
                        end else begin
                            o_state.day   = 5'd1;
                            o_state.month = i_state.month + MONTH_W'(1);
                        end
                    end else begin
                        o_state.day = i_state.day + DAY_W'(1);
                    end
                end
            end
            FUNC_PREV: begin
                if (i_state.ok) begin
                    if (i_state.day > 5'd1) begin
                        o_state.day = i_state.day - DAY_W'(1);
                    end else if (i_state.month == 4'd1) begin
                        if (i_state.year != '0) begin
                            o_state.day   = 5'd31;
                            o_state.month = 4'd12;
                            o_state.year  = year_m1;
                            o_state.leap  = leap_m1;
                        end
                    end else begin
                        o_state.day   = dim_prev;
                        o_state.month = i_state.month - MONTH_W'(1);
                    end
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

// ===== hw/rtl/calendar_date_counter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_counter_core
// Gregorian date register with load, day stepping and weekday output.
// ----------------------------------------------------------------------------
//  Channel  Handshake                  Word
//  in       i_in_valid / o_in_ready    func, load_day, load_month, load_year
//  out      o_out_valid / i_out_ready  date, year known, date valid, weekday
//
//  One word per cycle sustained while i_out_ready holds; an accepted word
//  passes input reg, date reg, weekday sum and output reg to o_out_valid.
//  The date step is combinational into the date reg; the weekday is split
//  into divide by 100 (weekday sum reg), then modulo 7 (output reg).
//  Reset clears the date to unknown and empties the pipeline.
//  Each stage holds while the next one is full and stalled; bubbles close up.
// ----------------------------------------------------------------------------
module calendar_date_counter_core #(
    parameter int unsigned LAST_YEAR = cdate_pkg::DEF_LAST_YEAR
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_func,
    input  logic [cdate_pkg::DAY_W-1:0]         i_load_day,
    input  logic [cdate_pkg::MONTH_W-1:0]       i_load_month,
    input  logic [cdate_pkg::YEAR_W-1:0]        i_load_year,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [cdate_pkg::DAY_W-1:0]         o_day_out,
    output logic [cdate_pkg::MONTH_W-1:0]       o_month_out,
    output logic [cdate_pkg::YEAR_W-1:0]        o_year_out,
    output logic                                o_year_is_known,
    output logic                                o_date_valid,
    output logic [2:0]                          o_weekday
);
    import cdate_pkg::*;

    // floor((26m - 2) / 10) for the March-based month index
    function automatic logic [4:0] month_term(input logic [MONTH_W-1:0] m);
        logic [4:0] t;
        unique case (m)
            4'd1:    t = 5'd2;
            4'd2:    t = 5'd5;
            4'd3:    t = 5'd7;
            4'd4:    t = 5'd10;
            4'd5:    t = 5'd12;
            4'd6:    t = 5'd15;
            4'd7:    t = 5'd18;
            4'd8:    t = 5'd20;
            4'd9:    t = 5'd23;
            4'd10:   t = 5'd25;
            4'd11:   t = 5'd28;
            4'd12:   t = 5'd31;
            default: t = 5'd0;
        endcase
        return t;
    endfunction

    // x mod 7 by reciprocal multiply, exact for x below 1644
    function automatic logic [2:0] mod7(input logic [10:0] x);
        logic [21:0] p;
        logic [7:0]  q;
        logic [10:0] r;
        p = 22'(x) * 22'd1171;
        q = p[20:13];
        r = x - 11'(q) * 11'd7;
        return r[2:0];
    endfunction

    logic ready0;
    logic ready1;
    logic ready2;
    logic ready3;

    // stage 0: input register
    logic                r_v0;
    logic [1:0]          r_func;
    logic [DAY_W-1:0]    r_ld_day;
    logic [MONTH_W-1:0]  r_ld_month;
    logic [YEAR_W-1:0]   r_ld_year;

    // stage 1: date register
    logic                r_v1;
    t_date_state         r_cur;
    t_date_state         n_cur;

    // stage 2: weekday sum
    logic                r_v2;
    logic [DAY_W-1:0]    r_s2_day;
    logic [MONTH_W-1:0]  r_s2_month;
    logic [YEAR_W-1:0]   r_s2_year;
    logic                r_s2_known;
    logic                r_s2_ok;
    logic [10:0]         r_s2_sum;
    logic [10:0]         n_s2_sum;

    // stage 3: output register
    logic                r_v3;
    logic [DAY_W-1:0]    r_s3_day;
    logic [MONTH_W-1:0]  r_s3_month;
    logic [YEAR_W-1:0]   r_s3_year;
    logic                r_s3_known;
    logic                r_s3_ok;
    logic [2:0]          r_s3_wday;

    logic                mar_based;
    logic [MONTH_W-1:0]  zm;
    logic [14:0]         zy;
    logic [7:0]          zs;
    logic [6:0]          ze;

    assign ready3     = !r_v3 || i_out_ready;
    assign ready2     = !r_v2 || ready3;
    assign ready1     = !r_v1 || ready2;
    assign ready0     = !r_v0 || ready1;
    assign o_in_ready = ready0;

    cdate_step #(
        .LAST_YEAR    (LAST_YEAR)
    ) u_step (
        .i_state      (r_cur),
        .i_func       (r_func),
        .i_load_day   (r_ld_day),
        .i_load_month (r_ld_month),
        .i_load_year  (r_ld_year),
        .o_state      (n_cur)
    );

    // Zeller terms; Jan/Feb count in the previous year, year offset by 400
    assign mar_based = (r_cur.month <= 4'd2);
    assign zm        = mar_based ? (r_cur.month + MONTH_W'(10))
                                 : (r_cur.month - MONTH_W'(2));
    assign zy        = 15'(r_cur.year) + 15'd400 - (mar_based ? 15'd1 : 15'd0);
    assign zs        = div100(zy);
    assign ze        = 7'(zy - 15'(zs) * 15'd100);
    assign n_s2_sum  = 11'(r_cur.day) + 11'(month_term(zm)) + 11'(ze)
                     + 11'(ze >> 2) + 11'(zs >> 2) + 11'(zs) * 11'd5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0  <= 1'b0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_cur <= '{day: '0, month: '0, year: '0, known: 1'b0,
                       leap: 1'b1, ok: 1'b0};
        end else begin
            if (ready0) begin
                r_v0 <= i_in_valid;
            end
            if (ready1) begin
                r_v1 <= r_v0;
                if (r_v0) begin
                    r_cur <= n_cur;
                end
            end
            if (ready2) begin
                r_v2 <= r_v1;
            end
            if (ready3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready0 && i_in_valid) begin
            r_func     <= i_func;
            r_ld_day   <= i_load_day;
            r_ld_month <= i_load_month;
            r_ld_year  <= i_load_year;
        end
        if (ready2 && r_v1) begin
            r_s2_day   <= r_cur.day;
            r_s2_month <= r_cur.month;
            r_s2_year  <= r_cur.year;
            r_s2_known <= r_cur.known;
            r_s2_ok    <= r_cur.ok;
            r_s2_sum   <= n_s2_sum;
        end
        if (ready3 && r_v2) begin
            r_s3_day   <= r_s2_day;
            r_s3_month <= r_s2_month;
            r_s3_year  <= r_s2_year;
            r_s3_known <= r_s2_known;
            r_s3_ok    <= r_s2_ok;
            r_s3_wday  <= r_s2_ok ? mod7(r_s2_sum) : 3'd0;
        end
    end

    assign o_out_valid     = r_v3;
    assign o_day_out       = r_s3_day;
    assign o_month_out     = r_s3_month;
    assign o_year_out      = r_s3_year;
    assign o_year_is_known = r_s3_known;
    assign o_date_valid    = r_s3_ok;
    assign o_weekday       = r_s3_wday;

endmodule
